@@ src/sfdc_pkg.sv @@
package sfdc_pkg;

    localparam logic [7:0] SYNC_A = 8'hdc;
    localparam logic [7:0] SYNC_B = 8'hc0;
    localparam logic [7:0] SYNC_C = 8'h23;
    localparam logic [7:0] SYNC_D = 8'hc2;

    typedef enum logic [3:0] {
        PH_SYNC0   = 4'd0,
        PH_SYNC1   = 4'd1,
        PH_SYNC2   = 4'd2,
        PH_SYNC3   = 4'd3,
        PH_SYNC4   = 4'd4,
        PH_SYNC5   = 4'd5,
        PH_SYNC6   = 4'd6,
        PH_SYNC7   = 4'd7,
        PH_CHK_LO  = 4'd8,
        PH_CHK_HI  = 4'd9,
        PH_LEN_HI  = 4'd10,
        PH_LEN_LO  = 4'd11,
        PH_RES0    = 4'd12,
        PH_RES1    = 4'd13,
        PH_PAYLOAD = 4'd14
    } t_phase;

    // The sync word is sent twice, so the pattern repeats every four bytes.
    function automatic logic [7:0] sync_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = SYNC_A;
            2'd1: b = SYNC_B;
            2'd2: b = SYNC_C;
            default: b = SYNC_D;
        endcase
        return b;
    endfunction

    // 16-bit byte sum with end-around carry.
    function automatic logic [15:0] add_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [16:0] s;
        s = {1'b0, acc} + {9'd0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

@@ src/sync_frame_deframer_checksum_unit.sv @@
// Each result is registered when its byte is accepted.
// Throughput: one byte per cycle while the input is not stalled; the frame state advances in a single step per byte.
// A byte is taken while a result waits, unless the result is stalled downstream.
// Reset (synchronous, active low) returns the deframer to hunting the first sync
// byte, clears the sum, checksum and length, and empties the result register.
module sync_frame_deframer_checksum_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_has_payload,
    output logic       o_frame_end,
    output logic       o_frame_good
);

    sfdc_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_check, n_check;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_len_hi, n_len_hi;

    logic        r_out_valid;
    logic [7:0]  r_payload_byte;
    logic        r_has_payload;
    logic        r_frame_end;
    logic        r_frame_good;

    logic        res_valid;
    logic [7:0]  res_payload_byte;
    logic        res_has_payload;
    logic        res_frame_end;
    logic        res_frame_good;

    logic        accept;
    logic [15:0] sum_add;
    logic [15:0] left_dec;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign sum_add    = sfdc_pkg::add_byte(r_sum, i_rx_byte);
    assign left_dec   = r_left - 16'd1;

    // Next state.
    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_check  = r_check;
        n_left   = r_left;
        n_len_hi = r_len_hi;
        case (r_phase)
            sfdc_pkg::PH_SYNC0, sfdc_pkg::PH_SYNC1, sfdc_pkg::PH_SYNC2,
            sfdc_pkg::PH_SYNC3, sfdc_pkg::PH_SYNC4, sfdc_pkg::PH_SYNC5,
            sfdc_pkg::PH_SYNC6, sfdc_pkg::PH_SYNC7: begin
                if (i_rx_byte == sfdc_pkg::sync_byte(r_phase[1:0])) begin
                    n_sum   = (r_phase == sfdc_pkg::PH_SYNC0) ? {8'd0, i_rx_byte} : sum_add;
                    n_phase = sfdc_pkg::t_phase'(r_phase + 4'd1);
                end else if (i_rx_byte == sfdc_pkg::SYNC_A) begin
                    // A mismatching byte may itself open a new sync word.
                    n_sum   = {8'd0, i_rx_byte};
                    n_phase = sfdc_pkg::PH_SYNC1;
                end else begin
                    n_sum   = 16'd0;
                    n_phase = sfdc_pkg::PH_SYNC0;
                end
            end
            sfdc_pkg::PH_CHK_LO: begin
                n_check = {8'd0, i_rx_byte};
                n_phase = sfdc_pkg::PH_CHK_HI;
            end
            sfdc_pkg::PH_CHK_HI: begin
                n_check = {i_rx_byte, r_check[7:0]};
                n_phase = sfdc_pkg::PH_LEN_HI;
            end
            sfdc_pkg::PH_LEN_HI: begin
                n_len_hi = i_rx_byte;
                n_sum    = sum_add;
                n_phase  = sfdc_pkg::PH_LEN_LO;
            end
            sfdc_pkg::PH_LEN_LO: begin
                n_left  = {r_len_hi, i_rx_byte};
                n_sum   = sum_add;
                n_phase = sfdc_pkg::PH_RES0;
            end
            sfdc_pkg::PH_RES0: begin
                n_sum   = sum_add;
                n_phase = sfdc_pkg::PH_RES1;
            end
            sfdc_pkg::PH_RES1: begin
                n_sum   = sum_add;
                n_phase = (r_left == 16'd0) ? sfdc_pkg::PH_SYNC0 : sfdc_pkg::PH_PAYLOAD;
            end
            sfdc_pkg::PH_PAYLOAD: begin
                n_sum   = sum_add;
                n_left  = left_dec;
                n_phase = (left_dec == 16'd0) ? sfdc_pkg::PH_SYNC0 : sfdc_pkg::PH_PAYLOAD;
            end
            default: begin
                // The unused phase code behaves as hunting the first sync byte.
                if (i_rx_byte == sfdc_pkg::SYNC_A) begin
                    n_sum   = {8'd0, i_rx_byte};
                    n_phase = sfdc_pkg::PH_SYNC1;
                end else begin
                    n_sum   = 16'd0;
                    n_phase = sfdc_pkg::PH_SYNC0;
                end
            end
        endcase
    end

    // Result for the current byte.
    always_comb begin
        res_valid        = 1'b0;
        res_payload_byte = 8'd0;
        res_has_payload  = 1'b0;
        res_frame_end    = 1'b0;
        res_frame_good   = 1'b0;
        case (r_phase)
            sfdc_pkg::PH_RES1: begin
                if (r_left == 16'd0) begin
                    res_valid      = 1'b1;
                    res_frame_end  = 1'b1;
                    res_frame_good = (sum_add == r_check);
                end
            end
            sfdc_pkg::PH_PAYLOAD: begin
                res_valid        = 1'b1;
                res_payload_byte = i_rx_byte;
                res_has_payload  = 1'b1;
                res_frame_end    = (left_dec == 16'd0);
                res_frame_good   = (left_dec == 16'd0) && (sum_add == r_check);
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfdc_pkg::PH_SYNC0;
            r_sum    <= 16'd0;
            r_check  <= 16'd0;
            r_left   <= 16'd0;
            r_len_hi <= 8'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_check  <= n_check;
            r_left   <= n_left;
            r_len_hi <= n_len_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_payload_byte <= res_payload_byte;
            r_has_payload  <= res_has_payload;
            r_frame_end    <= res_frame_end;
            r_frame_good   <= res_frame_good;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_payload_byte;
    assign o_has_payload  = r_has_payload;
    assign o_frame_end    = r_frame_end;
    assign o_frame_good   = r_frame_good;

endmodule
